// ----- hw/rtl/vcodec_pkg.sv -----
// ----------------------------------------------------------------------------
// vcodec_pkg
// Shared types and constants for the 32-bit varint codec.
// ----------------------------------------------------------------------------
package vcodec_pkg;

	localparam int MaxBytes   = 5;
	localparam int GroupBits  = 7;
	localparam int ValueWidth = 32;
	localparam int CountWidth = 3;
	localparam int QueueDepth = 4;

	localparam logic [7:0] GroupMask = 8'h7F;
	localparam logic [7:0] MoreBit   = 8'h80;

	localparam logic CmdEncode = 1'b0;
	localparam logic CmdDecode = 1'b1;

	typedef enum logic [1:0] {
		KIND_ENC_BYTE = 2'd0,
		KIND_DEC_VAL  = 2'd1,
		KIND_DEC_LONG = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                   kind;
		logic [ValueWidth-1:0]   data;
		logic [CountWidth-1:0]   count;
	} entry_t;

endpackage

// ----- hw/rtl/vcodec_front.sv -----
// ----------------------------------------------------------------------------
// vcodec_front
// Accepts commands, runs the decode accumulator, sizes encodes and queues work.
// ----------------------------------------------------------------------------
module vcodec_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       command,
	input  logic signed [31:0]         operand,
	input  logic                       q_full,
	output logic                       q_push,
	output vcodec_pkg::entry_t         q_entry
);

	logic [31:0] acc_q;
	logic [2:0]  seen_q;
	logic        accept;
	logic [7:0]  dbyte;
	logic [5:0]  pos;
	logic [31:0] acc_merge;
	logic [2:0]  enc_len;
	logic        too_long;
	logic [31:0] opnd;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign opnd   = operand;
	assign dbyte  = opnd[7:0];
	assign pos    = {seen_q, 3'b000} - {3'b000, seen_q};
	assign acc_merge = acc_q | ({24'd0, dbyte & vcodec_pkg::GroupMask} << pos);
	assign too_long  = (seen_q >= 3'(vcodec_pkg::MaxBytes));

	assign enc_len = 3'd1 + 3'(opnd[31:7] != '0) + 3'(opnd[31:14] != '0)
		+ 3'(opnd[31:21] != '0) + 3'(opnd[31:28] != '0);

	always_comb begin
		q_push        = 1'b0;
		q_entry.kind  = vcodec_pkg::KIND_ENC_BYTE;
		q_entry.data  = opnd;
		q_entry.count = enc_len;
		if (accept) begin
			if (command == vcodec_pkg::CmdEncode) begin
				q_push = 1'b1;
			end else if (too_long) begin
				q_push        = 1'b1;
				q_entry.kind  = vcodec_pkg::KIND_DEC_LONG;
				q_entry.data  = '0;
				q_entry.count = '0;
			end else if ((dbyte & vcodec_pkg::MoreBit) == 8'd0) begin
				q_push        = 1'b1;
				q_entry.kind  = vcodec_pkg::KIND_DEC_VAL;
				q_entry.data  = acc_merge;
				q_entry.count = seen_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			seen_q <= '0;
		end else if (accept) begin
			if (command == vcodec_pkg::CmdEncode || too_long ||
			    (dbyte & vcodec_pkg::MoreBit) == 8'd0) begin
				acc_q  <= '0;
				seen_q <= '0;
			end else begin
				acc_q  <= acc_merge;
				seen_q <= seen_q + 3'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= 3'(vcodec_pkg::MaxBytes))
		else $error("decode byte count out of range");
	a_too_long_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == vcodec_pkg::CmdDecode && too_long) |=> (seen_q == 3'd0))
		else $error("overlong decode not flushed");
`endif

endmodule

// ----- hw/rtl/vcodec_queue.sv -----
// ----------------------------------------------------------------------------
// vcodec_queue
// Small register queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
module vcodec_queue #(
	parameter int DEPTH = vcodec_pkg::QueueDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  vcodec_pkg::entry_t   wr_entry,
	output logic                 q_full,
	input  logic                 rd_en,
	output vcodec_pkg::entry_t   rd_entry,
	output logic                 q_avail
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	vcodec_pkg::entry_t mem [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign q_full   = (count_q == CntW'(DEPTH));
	assign q_avail  = (count_q != '0);
	assign do_wr    = wr_en && !q_full;
	assign do_rd    = rd_en && q_avail;
	assign rd_entry = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("queue count overflow");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !q_full)
		else $error("write into full queue");
`endif

endmodule

// ----- hw/rtl/vcodec_back.sv -----
// ----------------------------------------------------------------------------
// vcodec_back
// Takes queued work, emits a beat per cycle to the output reg unless stalled.
// ----------------------------------------------------------------------------
module vcodec_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vcodec_pkg::entry_t   head,
	input  logic                 q_avail,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output logic [1:0]           kind,
	output logic [7:0]           out_byte,
	output logic signed [31:0]   decoded_value,
	output logic [2:0]           byte_count,
	output logic                 last
);

	typedef vcodec_pkg::kind_t kind_t_local;

	logic        out_valid_q;
	kind_t_local out_kind_q;
	logic [7:0]  out_byte_q;
	logic [31:0] out_value_q;
	logic [2:0]  out_count_q;
	logic        out_last_q;

	logic        busy_q;
	logic [24:0] work_data_q;
	logic [2:0]  work_left_q;
	logic [2:0]  work_len_q;

	logic        load;

	assign load  = !out_valid_q || pop;
	assign q_pop = load && !busy_q && q_avail;

	assign empty         = !out_valid_q;
	assign kind          = out_kind_q;
	assign out_byte      = out_byte_q;
	assign decoded_value = out_value_q;
	assign byte_count    = out_count_q;
	assign last          = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
		end else if (load) begin
			if (busy_q) begin
				out_valid_q <= 1'b1;
				busy_q      <= (work_left_q != 3'd1);
			end else if (q_avail) begin
				out_valid_q <= 1'b1;
				busy_q      <= (head.kind == vcodec_pkg::KIND_ENC_BYTE) &&
					(head.count != 3'd1);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (busy_q) begin
				out_kind_q  <= vcodec_pkg::KIND_ENC_BYTE;
				out_byte_q  <= {(work_left_q != 3'd1), work_data_q[6:0]};
				out_value_q <= '0;
				out_count_q <= work_len_q;
				out_last_q  <= (work_left_q == 3'd1);
				work_data_q <= work_data_q >> vcodec_pkg::GroupBits;
				work_left_q <= work_left_q - 3'd1;
			end else if (q_avail) begin
				out_kind_q  <= head.kind;
				out_count_q <= head.count;
				work_data_q <= head.data[31:7];
				work_left_q <= head.count - 3'd1;
				work_len_q  <= head.count;
				if (head.kind == vcodec_pkg::KIND_ENC_BYTE) begin
					out_byte_q  <= {(head.count != 3'd1), head.data[6:0]};
					out_value_q <= '0;
					out_last_q  <= (head.count == 3'd1);
				end else begin
					out_byte_q  <= '0;
					out_value_q <= head.data;
					out_last_q  <= 1'b1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_busy_left: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (work_left_q != 3'd0 &&
			work_left_q < 3'(vcodec_pkg::MaxBytes)))
		else $error("encode byte counter out of range");
`endif

endmodule

// ----- hw/rtl/varint32_codec.sv -----
// ----------------------------------------------------------------------------
// varint32_codec
// 32-bit LEB128 varint encoder and decoder with queue-style ports.
//
//   channel  | handshake    | payload
//   ---------+--------------+------------------------------------------------
//   input    | push / full  | command, operand
//   result   | empty / pop  | kind, out_byte, decoded_value, byte_count, last
//
// A decode byte is taken every cycle while the work queue has room.
// An encode is taken as a single item and yields 1 to 5 beats, one per cycle
// while pop keeps up, paced by the byte sequencer in the back end.
// The first result beat goes through the work queue and the output register.
// arst_n clears the decode accumulator, the queue and the output valid flag.
// A stalled result side fills the queue, then raises full.
// ----------------------------------------------------------------------------
module varint32_codec #(
	parameter int QUEUE_DEPTH = vcodec_pkg::QueueDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 command,
	input  logic signed [31:0]   operand,
	input  logic                 pop,
	output logic                 empty,
	output logic [1:0]           kind,
	output logic [7:0]           out_byte,
	output logic signed [31:0]   decoded_value,
	output logic [2:0]           byte_count,
	output logic                 last
);

	logic               q_full;
	logic               q_push;
	vcodec_pkg::entry_t q_wr_entry;
	logic               q_pop;
	vcodec_pkg::entry_t q_head;
	logic               q_avail;

	vcodec_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.command (command),
		.operand (operand),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_wr_entry)
	);

	vcodec_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_entry (q_wr_entry),
		.q_full   (q_full),
		.rd_en    (q_pop),
		.rd_entry (q_head),
		.q_avail  (q_avail)
	);

	vcodec_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.q_avail       (q_avail),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.kind          (kind),
		.out_byte      (out_byte),
		.decoded_value (decoded_value),
		.byte_count    (byte_count),
		.last          (last)
	);

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for varint32_codec. Encode and decode items go in over
// the push/full side while a scoreboard predicts every result beat from its
// own copy of the decode accumulator. Each beat taken over empty/pop is
// checked field by field against the oldest prediction. Directed cases
// cover the encode length edges, the longest decode, the too-long error
// and an encode that cuts off a decode. Random well-formed and broken
// sequences follow. Both sides idle in short bursts, and one long result
// stall backs the block up until it raises full.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 200000;
	localparam int RandItems  = 66;
	localparam int ShowLimit  = 10;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic               command;
	logic signed [31:0] operand;
	logic               pop;
	logic               empty;
	logic [1:0]         kind;
	logic [7:0]         out_byte;
	logic signed [31:0] decoded_value;
	logic [2:0]         byte_count;
	logic               last;

	typedef struct {
		vcodec_pkg::kind_t kind;
		logic [7:0]        code;
		logic [31:0]       value;
		logic [2:0]        count;
		logic              fin;
	} beat_t;

	beat_t       pending_beats[$];
	logic [31:0] dec_acc;
	int unsigned dec_len;
	int unsigned mismatches;
	int unsigned cycles;
	bit          gap_en;
	bit          stall_en;
	bit          hold_req;
	int unsigned hold_len;

	varint32_codec dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.command       (command),
		.operand       (operand),
		.pop           (pop),
		.empty         (empty),
		.kind          (kind),
		.out_byte      (out_byte),
		.decoded_value (decoded_value),
		.byte_count    (byte_count),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// queues the beats one accepted item should produce
	function automatic void predict_beats(input logic cmd, input logic [31:0] opnd);
		beat_t       b;
		int unsigned n;
		logic [31:0] rest;
		logic [7:0]  data;
		if (cmd == vcodec_pkg::CmdEncode) begin
			dec_acc = '0;
			dec_len = 0;
			n = 1;
			rest = opnd >> vcodec_pkg::GroupBits;
			while (rest != 0 && n < vcodec_pkg::MaxBytes) begin
				n++;
				rest = rest >> vcodec_pkg::GroupBits;
			end
			for (int i = 0; i < n; i++) begin
				b.kind = vcodec_pkg::KIND_ENC_BYTE;
				b.code = 8'(opnd >> (vcodec_pkg::GroupBits * i)) & vcodec_pkg::GroupMask;
				if (i < n - 1)
					b.code = b.code | vcodec_pkg::MoreBit;
				b.value = '0;
				b.count = 3'(n);
				b.fin = (i == n - 1);
				pending_beats.push_back(b);
			end
		end else begin
			data = opnd[7:0];
			if (dec_len >= vcodec_pkg::MaxBytes) begin
				dec_acc = '0;
				dec_len = 0;
				b = '{vcodec_pkg::KIND_DEC_LONG, 8'h00, 32'h0, 3'd0, 1'b1};
				pending_beats.push_back(b);
			end else begin
				dec_acc = dec_acc | (32'(data & vcodec_pkg::GroupMask)
					<< (vcodec_pkg::GroupBits * dec_len));
				dec_len++;
				if ((data & vcodec_pkg::MoreBit) == 8'h00) begin
					b = '{vcodec_pkg::KIND_DEC_VAL, 8'h00, dec_acc, 3'(dec_len), 1'b1};
					pending_beats.push_back(b);
					dec_acc = '0;
					dec_len = 0;
				end
			end
		end
	endfunction

	always @(posedge clk) begin
		beat_t want;
		if (arst_n && push && !full)
			predict_beats(command, operand);
		if (arst_n && pop && !empty) begin
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= ShowLimit)
					$display("unexpected beat: kind %0d byte %02h value %08h count %0d last %0d",
						kind, out_byte, decoded_value, byte_count, last);
			end else begin
				want = pending_beats.pop_front();
				if (kind !== want.kind || out_byte !== want.code ||
					decoded_value !== want.value || byte_count !== want.count ||
					last !== want.fin) begin
					mismatches++;
					if (mismatches <= ShowLimit) begin
						$display("beat mismatch: exp kind %0d byte %02h value %08h count %0d last %0d",
							want.kind, want.code, want.value, want.count, want.fin);
						$display("                got kind %0d byte %02h value %08h count %0d last %0d",
							kind, out_byte, decoded_value, byte_count, last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: short stall bursts, or one long hold-off on request
	initial begin
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall_en && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			pop <= 1'b1;
		end
	end

	// returns at the edge where the beat is taken
	task automatic push_item(input logic cmd, input logic [31:0] opnd);
		if (gap_en && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		operand <= opnd;
		do @(posedge clk); while (full);
	endtask

	task automatic test_encode_lengths();
		logic [31:0] vals[7] = '{32'h0000_0000, 32'h0000_0080, 32'h0FFF_FFFF,
			32'h1000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
		foreach (vals[i])
			push_item(vcodec_pkg::CmdEncode, vals[i]);
	endtask

	task automatic test_decode_longest();
		// upper operand bits must be ignored
		push_item(vcodec_pkg::CmdDecode, 32'hFFFF_FF7F);
		// five bytes, top group overflows bit 31
		repeat (4) push_item(vcodec_pkg::CmdDecode, 32'h0000_00FF);
		push_item(vcodec_pkg::CmdDecode, 32'h0000_007F);
	endtask

	task automatic test_decode_too_long();
		repeat (vcodec_pkg::MaxBytes) push_item(vcodec_pkg::CmdDecode, 32'h0000_0080);
		push_item(vcodec_pkg::CmdDecode, 32'h0000_0001);
		repeat (vcodec_pkg::MaxBytes) push_item(vcodec_pkg::CmdDecode, 32'h0000_0080);
		push_item(vcodec_pkg::CmdDecode, 32'h0000_0081);
	endtask

	task automatic test_encode_abandons_decode();
		push_item(vcodec_pkg::CmdDecode, 32'h0000_0085);
		push_item(vcodec_pkg::CmdEncode, 32'd300);
		push_item(vcodec_pkg::CmdDecode, 32'h0000_0001);
	endtask

	task automatic test_backpressure();
		hold_len = 80;
		hold_req = 1'b1;
		repeat (16) push_item(vcodec_pkg::CmdEncode, $urandom() | 32'h1000_0000);
	endtask

	task automatic test_random(input int unsigned count);
		int unsigned n;
		int unsigned sel;
		int unsigned len;
		logic [31:0] v;
		n = 0;
		while (n < count) begin
			if (n + 30 >= count) begin
				gap_en = 1'b0;
				stall_en = 1'b0;
			end
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				push_item(vcodec_pkg::CmdEncode, $urandom() >> $urandom_range(0, 31));
				n++;
			end else if (sel < 8) begin
				len = $urandom_range(1, vcodec_pkg::MaxBytes);
				for (int k = 0; k < len; k++) begin
					v = $urandom();
					v[7] = (k < len - 1);
					push_item(vcodec_pkg::CmdDecode, v);
				end
				n += len;
			end else if (sel == 8) begin
				for (int k = 0; k <= vcodec_pkg::MaxBytes; k++) begin
					v = $urandom();
					if (k < vcodec_pkg::MaxBytes)
						v[7] = 1'b1;
					push_item(vcodec_pkg::CmdDecode, v);
				end
				n += vcodec_pkg::MaxBytes + 1;
			end else begin
				push_item(1'($urandom_range(0, 1)), $urandom());
				n++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		command = vcodec_pkg::CmdEncode;
		operand = '0;
		dec_acc = '0;
		dec_len = 0;
		mismatches = 0;
		cycles = 0;
		gap_en = 1'b1;
		stall_en = 1'b1;
		hold_req = 1'b0;
		hold_len = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_encode_lengths();
		test_decode_longest();
		test_decode_too_long();
		test_encode_abandons_decode();
		test_backpressure();
		test_random(RandItems);

		push <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
